// ----- hw/rtl/framed_packet_crc8_checker_top_assert.svh -----
// Assertion macros for the framed packet CRC-8 checker.
// Needs signals clk and arst_n in the scope that uses them.
`ifndef FRAMED_PACKET_CRC8_CHECKER_TOP_ASSERT_SVH
`define FRAMED_PACKET_CRC8_CHECKER_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FPCC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define FPCC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/fpcc_pkg.sv -----
// Shared types and constants of the framed packet CRC-8 checker.
// No dependencies; imported by every module of the block.
package fpcc_pkg;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int CNT_W   = 10;

	// operation codes on kind
	localparam logic [1:0] KIND_PUSH  = 2'd0;
	localparam logic [1:0] KIND_CHECK = 2'd1;
	localparam logic [1:0] KIND_POP   = 2'd2;

	// result status codes
	localparam logic [2:0] ST_STORED    = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_NEED_MORE = 3'd2;
	localparam logic [2:0] ST_FRAME     = 3'd3;
	localparam logic [2:0] ST_DISCARD   = 3'd4;
	localparam logic [2:0] ST_BYTE_OUT  = 3'd5;
	localparam logic [2:0] ST_EMPTY     = 3'd6;

	typedef struct packed {
		logic [7:0] header_byte;
		logic [7:0] crc_polynomial;
		logic [6:0] min_window;
		logic [7:0] min_length;
	} fpcc_cfg_t;

	typedef enum logic [2:0] {
		OFF_HOLD,
		OFF_ZERO,
		OFF_ONE,
		OFF_TWO,
		OFF_INC
	} off_op_t;

	typedef enum logic [3:0] {
		RES_NONE,
		RES_STORED,
		RES_FULL,
		RES_NEED,
		RES_FRAME,
		RES_DISC_FOUND,
		RES_DISC_ALL,
		RES_BYTE_OUT,
		RES_EMPTY
	} res_op_t;

	typedef struct packed {
		off_op_t off_op;
		res_op_t res;
		logic    rx_latch;
		logic    push_wr;
		logic    pop_adv;
		logic    hdr_latch;
		logic    addr_latch;
		logic    len_latch;
		logic    crc_step;
	} fpcc_cmd_t;

	typedef struct packed {
		logic fill_zero;
		logic below_min;
		logic short3;
		logic full;
		logic hunting;
		logic hdr_ok;
		logic len_bad;
		logic len_short;
		logic crc_end;
		logic crc_match;
		logic rs_end;
		logic rs_match;
	} fpcc_sts_t;

endpackage

// ----- hw/rtl/fpcc_cfg.sv -----
// APB register file of the framed packet CRC-8 checker.
// Depends on fpcc_pkg for the register struct and bus widths.
module fpcc_cfg import fpcc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output fpcc_cfg_t          cfg
);

	localparam logic [1:0] REG_HEADER = 2'd0;
	localparam logic [1:0] REG_POLY   = 2'd1;
	localparam logic [1:0] REG_MINWIN = 2'd2;
	localparam logic [1:0] REG_MINLEN = 2'd3;

	fpcc_cfg_t cfg_q;
	logic      wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_byte    <= 8'hF7;
			cfg_q.crc_polynomial <= 8'h07;
			cfg_q.min_window     <= 7'd6;
			cfg_q.min_length     <= 8'd3;
		end else if (wr_en) begin
			case (reg_idx)
				REG_HEADER: cfg_q.header_byte    <= pwdata[7:0];
				REG_POLY:   cfg_q.crc_polynomial <= pwdata[7:0];
				REG_MINWIN: cfg_q.min_window     <= pwdata[6:0];
				REG_MINLEN: cfg_q.min_length     <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_HEADER: prdata = PDATA_W'(cfg_q.header_byte);
			REG_POLY:   prdata = PDATA_W'(cfg_q.crc_polynomial);
			REG_MINWIN: prdata = PDATA_W'(cfg_q.min_window);
			REG_MINLEN: prdata = PDATA_W'(cfg_q.min_length);
			default:    prdata = '0;
		endcase
	end

endmodule

// ----- hw/rtl/fpcc_ctrl.sv -----
// Controller state machine of the framed packet CRC-8 checker.
// Depends on fpcc_pkg for the command and status structs.
module fpcc_ctrl import fpcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] kind,
	input  fpcc_sts_t  sts,
	output fpcc_cmd_t  cmd,
	output logic       busy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH,
		S_POP,
		S_CHK,
		S_CHK_A,
		S_CHK_L,
		S_CRC,
		S_RS
	} state_t;

	state_t state_q, state_d;
	logic   busy_q;

	assign busy = busy_q;

	always_comb begin
		state_d        = state_q;
		cmd.off_op     = OFF_HOLD;
		cmd.res        = RES_NONE;
		cmd.rx_latch   = 1'b0;
		cmd.push_wr    = 1'b0;
		cmd.pop_adv    = 1'b0;
		cmd.hdr_latch  = 1'b0;
		cmd.addr_latch = 1'b0;
		cmd.len_latch  = 1'b0;
		cmd.crc_step   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					// offset 0 is read for every kind; pop and check need it next cycle
					cmd.rx_latch = 1'b1;
					cmd.off_op   = OFF_ZERO;
					case (kind)
						KIND_PUSH:  state_d = S_PUSH;
						KIND_CHECK: state_d = S_CHK;
						KIND_POP:   state_d = S_POP;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_PUSH: begin
				if (sts.full) begin
					cmd.res = RES_FULL;
				end else begin
					cmd.push_wr = 1'b1;
					cmd.res     = RES_STORED;
				end
				state_d = S_IDLE;
			end
			S_POP: begin
				if (sts.fill_zero) begin
					cmd.res = RES_EMPTY;
				end else begin
					cmd.pop_adv = 1'b1;
					cmd.res     = RES_BYTE_OUT;
				end
				state_d = S_IDLE;
			end
			S_CHK: begin
				if (sts.fill_zero || sts.below_min) begin
					cmd.res = RES_NEED;
					state_d = S_IDLE;
				end else if (sts.hunting) begin
					cmd.off_op = OFF_ONE;
					state_d    = S_RS;
				end else if (sts.short3) begin
					cmd.res = RES_NEED;
					state_d = S_IDLE;
				end else begin
					cmd.hdr_latch = 1'b1;
					cmd.off_op    = OFF_ONE;
					state_d       = S_CHK_A;
				end
			end
			S_CHK_A: begin
				cmd.addr_latch = 1'b1;
				cmd.off_op     = OFF_TWO;
				state_d        = S_CHK_L;
			end
			S_CHK_L: begin
				if (!sts.hdr_ok || sts.len_bad) begin
					cmd.off_op = OFF_ONE;
					state_d    = S_RS;
				end else if (sts.len_short) begin
					cmd.res = RES_NEED;
					state_d = S_IDLE;
				end else begin
					// offset stays at 2: the length byte is the first CRC byte
					cmd.len_latch = 1'b1;
					state_d       = S_CRC;
				end
			end
			S_CRC: begin
				if (sts.crc_end) begin
					if (sts.crc_match) begin
						cmd.res = RES_FRAME;
						state_d = S_IDLE;
					end else begin
						cmd.off_op = OFF_ONE;
						state_d    = S_RS;
					end
				end else begin
					cmd.crc_step = 1'b1;
					cmd.off_op   = OFF_INC;
				end
			end
			S_RS: begin
				if (sts.rs_end) begin
					cmd.res = RES_DISC_ALL;
					state_d = S_IDLE;
				end else if (sts.rs_match) begin
					cmd.res = RES_DISC_FOUND;
					state_d = S_IDLE;
				end else begin
					cmd.off_op = OFF_INC;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
		end
	end

endmodule

// ----- hw/rtl/fpcc_datapath.sv -----
// Datapath of the framed packet CRC-8 checker: window memory, pointers,
// byte offset, CRC register and result registers. Depends on fpcc_pkg.
module fpcc_datapath import fpcc_pkg::*; #(
	parameter int WINDOW_DEPTH = 512
) (
	input  logic             clk,
	input  logic             arst_n,
	input  fpcc_cfg_t        cfg,
	input  logic [7:0]       rx_byte,
	input  fpcc_cmd_t        cmd,
	output fpcc_sts_t        sts,
	output logic             done,
	output logic [2:0]       status,
	output logic [CNT_W-1:0] byte_count,
	output logic [7:0]       frame_address,
	output logic [7:0]       out_byte
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int FW = $clog2(WINDOW_DEPTH + 1);
	localparam logic [FW:0]   DEPTH_X = (FW+1)'(WINDOW_DEPTH);
	localparam logic [FW-1:0] DEPTH_F = FW'(WINDOW_DEPTH);
	localparam logic [AW-1:0] LAST_A  = AW'(WINDOW_DEPTH - 1);

	logic [7:0]    mem [WINDOW_DEPTH];
	logic [AW-1:0] start_q;
	logic [FW-1:0] fill_q;
	logic          hunting_q;
	logic [FW-1:0] off_q, off_d;
	logic [7:0]    rdata_q;
	logic [7:0]    rx_q;
	logic          hdr_ok_q;
	logic [7:0]    addr_q;
	logic [7:0]    len_q;
	logic [7:0]    crc_q;
	logic          done_q;
	logic [2:0]    status_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]    faddr_q;
	logic [7:0]    obyte_q;
	logic [FW:0]   rd_sum, wr_sum;
	logic [AW-1:0] rd_addr, wr_addr;

	// MSB-first CRC-8 over one byte, eight shift steps
	function automatic logic [7:0] crc8_next(input logic [7:0] crc_in,
	                                         input logic [7:0] data,
	                                         input logic [7:0] poly);
		logic [7:0] c;
		c = crc_in ^ data;
		for (int b = 0; b < 8; b++) begin
			c = c[7] ? ((c << 1) ^ poly) : (c << 1);
		end
		return c;
	endfunction

	always_comb begin
		case (cmd.off_op)
			OFF_HOLD: off_d = off_q;
			OFF_ZERO: off_d = '0;
			OFF_ONE:  off_d = FW'(1);
			OFF_TWO:  off_d = FW'(2);
			OFF_INC:  off_d = off_q + FW'(1);
			default:  off_d = off_q;
		endcase
	end

	// start + offset stays below twice the depth: one conditional subtract wraps it
	always_comb begin
		rd_sum = (FW+1)'(start_q) + (FW+1)'(off_d);
		if (rd_sum >= DEPTH_X) begin
			rd_sum = rd_sum - DEPTH_X;
		end
		rd_addr = rd_sum[AW-1:0];
		wr_sum = (FW+1)'(start_q) + (FW+1)'(fill_q);
		if (wr_sum >= DEPTH_X) begin
			wr_sum = wr_sum - DEPTH_X;
		end
		wr_addr = wr_sum[AW-1:0];
	end

	// rdata_q always holds the window byte at off_q
	always_ff @(posedge clk) begin
		if (cmd.push_wr) begin
			mem[wr_addr] <= rx_q;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= '0;
			fill_q    <= '0;
			hunting_q <= 1'b0;
			off_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			off_q  <= off_d;
			done_q <= (cmd.res != RES_NONE);
			if (cmd.push_wr) begin
				fill_q <= fill_q + FW'(1);
			end else if (cmd.pop_adv) begin
				fill_q  <= fill_q - FW'(1);
				start_q <= (start_q == LAST_A) ? '0 : start_q + AW'(1);
			end
			if (cmd.res == RES_DISC_FOUND) begin
				hunting_q <= 1'b0;
			end else if (cmd.res == RES_DISC_ALL) begin
				hunting_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rx_latch) begin
			rx_q <= rx_byte;
		end
		if (cmd.hdr_latch) begin
			hdr_ok_q <= (rdata_q == cfg.header_byte);
		end
		if (cmd.addr_latch) begin
			addr_q <= rdata_q;
		end
		if (cmd.len_latch) begin
			len_q <= rdata_q;
			crc_q <= '0;
		end else if (cmd.crc_step) begin
			crc_q <= crc8_next(crc_q, rdata_q, cfg.crc_polynomial);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res != RES_NONE) begin
			count_q <= '0;
			faddr_q <= '0;
			obyte_q <= '0;
			case (cmd.res)
				RES_STORED: status_q <= ST_STORED;
				RES_FULL:   status_q <= ST_FULL;
				RES_NEED:   status_q <= ST_NEED_MORE;
				RES_FRAME: begin
					status_q <= ST_FRAME;
					count_q  <= CNT_W'(len_q) + CNT_W'(3);
					faddr_q  <= addr_q;
				end
				RES_DISC_FOUND: begin
					status_q <= ST_DISCARD;
					count_q  <= CNT_W'(off_q);
				end
				RES_DISC_ALL: begin
					status_q <= ST_DISCARD;
					count_q  <= CNT_W'(fill_q);
				end
				RES_BYTE_OUT: begin
					status_q <= ST_BYTE_OUT;
					obyte_q  <= rdata_q;
				end
				RES_EMPTY: status_q <= ST_EMPTY;
				default:   status_q <= ST_STORED;
			endcase
		end
	end

	assign sts.fill_zero = (fill_q == '0);
	assign sts.below_min = (fill_q < FW'(cfg.min_window));
	assign sts.short3    = (fill_q < FW'(3));
	assign sts.full      = (fill_q == DEPTH_F);
	assign sts.hunting   = hunting_q;
	assign sts.hdr_ok    = hdr_ok_q;
	assign sts.len_bad   = (rdata_q < cfg.min_length);
	assign sts.len_short = (fill_q < FW'(rdata_q) + FW'(3));
	assign sts.crc_end   = (off_q == FW'(len_q) + FW'(2));
	assign sts.crc_match = (crc_q == rdata_q);
	assign sts.rs_end    = (off_q >= fill_q);
	assign sts.rs_match  = (rdata_q == cfg.header_byte);

	assign done          = done_q;
	assign status        = status_q;
	assign byte_count    = count_q;
	assign frame_address = faddr_q;
	assign out_byte      = obyte_q;

endmodule

// ----- hw/rtl/framed_packet_crc8_checker_top.sv -----
// Framed packet CRC-8 checker: receive window with push, pop and check.
// Instantiates fpcc_cfg, fpcc_ctrl and fpcc_datapath; depends on fpcc_pkg.
//
// Usage:
//   Command channel: drive kind and rx_byte with start; the transaction is
//   taken at a rising edge where start is high and busy is low. kind 3 is
//   taken but does nothing and gives no result.
//   Result channel: done is high for one cycle with status, byte_count,
//   frame_address and out_byte. The receiver cannot stall; done always
//   falls in a cycle where busy is already low, so the next command may be
//   taken at the same edge that takes the result.
//   Push and pop pass through S_PUSH or S_POP before the done cycle.
//   Check: a window below the minimum ends in S_CHK; with a header and
//   length in place, a frame goes through S_CHK_A, S_CHK_L and S_CRC, the
//   window memory being read one byte a cycle for the CRC. A resync
//   searches one offset a cycle, up to fill, after the states that led to it.
//   Worst case is a bad CRC on a long frame followed by a search
//   through a full window.
//   Config: APB port, registers at byte addresses 0, 4, 8, 12; write only
//   while no transaction is in flight. pready is tied high.
//   Reset: arst_n clears the window pointers, fill and hunting flag and
//   loads the register defaults; window contents are not cleared.
module framed_packet_crc8_checker_top import fpcc_pkg::*; #(
	parameter int WINDOW_DEPTH = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         kind,
	input  logic [7:0]         rx_byte,
	output logic               done,
	output logic [2:0]         status,
	output logic [CNT_W-1:0]   byte_count,
	output logic [7:0]         frame_address,
	output logic [7:0]         out_byte
);

	fpcc_cfg_t cfg;
	fpcc_cmd_t cmd;
	fpcc_sts_t sts;

	fpcc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fpcc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	fpcc_datapath #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.rx_byte       (rx_byte),
		.cmd           (cmd),
		.sts           (sts),
		.done          (done),
		.status        (status),
		.byte_count    (byte_count),
		.frame_address (frame_address),
		.out_byte      (out_byte)
	);

endmodule

// ----- hw/rtl/fpcc_checker.sv -----
// Port-level assertions for the framed packet CRC-8 checker, bound to the top.
// Depends on fpcc_pkg and framed_packet_crc8_checker_top_assert.svh.
`include "framed_packet_crc8_checker_top_assert.svh"

module fpcc_checker import fpcc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic [1:0]       kind,
	input logic             done,
	input logic [2:0]       status,
	input logic [CNT_W-1:0] byte_count,
	input logic [7:0]       frame_address
);

	`FPCC_ASSERT_IMP(a_done_idle, done, !busy, "result strobe while busy")
	`FPCC_ASSERT_NXT(a_done_pulse, done, !done, "result strobe two cycles running")
	`FPCC_ASSERT_NXT(a_take_busy, start && !busy && (kind <= KIND_POP), busy, "busy not raised")
	`FPCC_ASSERT_IMP(a_frame_len, done && (status == ST_FRAME), byte_count >= CNT_W'(3), "short frame")
	`FPCC_ASSERT_IMP(a_addr_zero, done && (status != ST_FRAME), frame_address == 8'd0, "stray address")

endmodule

bind framed_packet_crc8_checker_top fpcc_checker u_fpcc_checker (.*);

// ----- bench/tb_framed_packet_crc8_checker_top.sv -----
// Testbench for framed_packet_crc8_checker_top: push/pop/check traffic checked against
// an in-bench model of the window, CRC-8 framing and resync rules.
// Depends on fpcc_pkg and the checker RTL only.
module tb_framed_packet_crc8_checker_top import fpcc_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN_DEPTH = 512;
	localparam int LIMIT_CYCLES = 10_000_000;
	localparam int ITEM_TARGET = 1750;
	localparam logic [1:0] KIND_NOP = 2'd3;
	localparam int REG_HEADER = 0;
	localparam int REG_POLY = 1;
	localparam int REG_MIN_WIN = 2;
	localparam int REG_MIN_LEN = 3;

	typedef struct {
		logic [1:0] kind;
		logic [7:0] data;
	} cmd_t;

	typedef struct {
		logic [2:0]       status;
		logic [CNT_W-1:0] count;
		logic [7:0]       addr;
		logic [7:0]       obyte;
	} op_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         kind = KIND_PUSH;
	logic [7:0]         rx_byte = 8'h00;
	logic               done;
	logic [2:0]         status;
	logic [CNT_W-1:0]   byte_count;
	logic [7:0]         frame_address;
	logic [7:0]         out_byte;

	framed_packet_crc8_checker_top #(.WINDOW_DEPTH(WIN_DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .kind(kind), .rx_byte(rx_byte),
		.done(done), .status(status), .byte_count(byte_count),
		.frame_address(frame_address), .out_byte(out_byte)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// model state
	fpcc_cfg_t   model_cfg;
	logic [7:0]  win_mem [WIN_DEPTH];
	int          win_head;
	int          win_fill;
	bit          hunting;
	op_result_t  last_check;

	cmd_t        cmd_fifo[$];
	op_result_t  pending_results[$];
	int          err_cnt = 0;
	int          issued = 0;
	int          idle_left = 0;
	bit          calm = 1'b0;
	int          cycles = 0;

	function automatic logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] b, logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ b;
		repeat (8) c = c[7] ? ((c << 1) ^ poly) : (c << 1);
		return c;
	endfunction

	function automatic logic [7:0] win_byte(int off);
		return win_mem[(win_head + off) % WIN_DEPTH];
	endfunction

	// search offsets 1.. for a header; none found drops the whole window
	function automatic int resync_count();
		for (int k = 1; k < win_fill; k++) begin
			if (win_byte(k) == model_cfg.header_byte) begin
				hunting = 1'b0;
				return k;
			end
		end
		hunting = 1'b1;
		return win_fill;
	endfunction

	function automatic void model_op(logic [1:0] k, logic [7:0] b);
		op_result_t r;
		int len;
		logic [7:0] crc;
		r = '{default: '0};
		case (k)
			KIND_PUSH: begin
				if (win_fill >= WIN_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					win_mem[(win_head + win_fill) % WIN_DEPTH] = b;
					win_fill++;
					r.status = ST_STORED;
				end
			end
			KIND_POP: begin
				if (win_fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.obyte = win_byte(0);
					win_head = (win_head + 1) % WIN_DEPTH;
					win_fill--;
					r.status = ST_BYTE_OUT;
				end
			end
			KIND_CHECK: begin
				if (win_fill == 0 || win_fill < model_cfg.min_window) begin
					r.status = ST_NEED_MORE;
				end else if (hunting) begin
					r.status = ST_DISCARD;
					r.count = CNT_W'(resync_count());
				end else if (win_fill < 3) begin
					r.status = ST_NEED_MORE;
				end else if (win_byte(0) != model_cfg.header_byte ||
						win_byte(2) < model_cfg.min_length) begin
					r.status = ST_DISCARD;
					r.count = CNT_W'(resync_count());
				end else begin
					len = win_byte(2);
					if (win_fill < len + 3) begin
						r.status = ST_NEED_MORE;
					end else begin
						crc = 8'h00;
						for (int i = 0; i < len; i++)
							crc = crc8_next(crc, win_byte(2 + i), model_cfg.crc_polynomial);
						if (crc == win_byte(2 + len)) begin
							r.status = ST_FRAME;
							r.count = CNT_W'(len + 3);
							r.addr = win_byte(1);
						end else begin
							r.status = ST_DISCARD;
							r.count = CNT_W'(resync_count());
						end
					end
				end
				last_check = r;
			end
			default: return;
		endcase
		pending_results.push_back(r);
	endfunction

	// command driver
	always @(posedge clk) begin : drv
		int gap;
		cmd_t c;
		if (!arst_n) begin
			start <= 1'b0;
			idle_left <= 0;
		end else begin
			if (start && !busy)
				model_op(kind, rx_byte);
			if (!start || !busy) begin
				gap = idle_left;
				if (start && !calm && $urandom_range(0, 3) == 0)
					gap = $urandom_range(1, 14);
				if (gap > 0) begin
					start <= 1'b0;
					idle_left <= gap - 1;
				end else if (cmd_fifo.size() != 0) begin
					c = cmd_fifo.pop_front();
					start <= 1'b1;
					kind <= c.kind;
					rx_byte <= c.data;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : mon
		op_result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result status %0d count %0d addr %h byte %h",
					$time, status, byte_count, frame_address, out_byte);
				err_cnt++;
			end else begin
				e = pending_results.pop_front();
				if (status !== e.status || byte_count !== e.count ||
						frame_address !== e.addr || out_byte !== e.obyte) begin
					$display(
						"%0t: mismatch expected st %0d cnt %0d addr %h byte %h, got st %0d cnt %0d addr %h byte %h",
						$time, e.status, e.count, e.addr, e.obyte,
						status, byte_count, frame_address, out_byte);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic put(logic [1:0] k, logic [7:0] b);
		cmd_fifo.push_back('{k, b});
		issued++;
	endtask

	task automatic pop_n(int n);
		for (int i = 0; i < n; i++)
			put(KIND_POP, 8'($urandom));
	endtask

	task automatic drain();
		do @(negedge clk);
		while (cmd_fifo.size() != 0 || start || busy || pending_results.size() != 0);
	endtask

	// idle before touching registers: kind 3 leaves nothing to wait on
	task automatic settle();
		drain();
		repeat (12) @(posedge clk);
	endtask

	task automatic reg_write(int idx, logic [7:0] val);
		logic [31:0] data;
		logic [31:0] mask;
		mask = (idx == REG_MIN_WIN) ? 32'h7F : 32'hFF;
		data = $urandom;
		data[7:0] = val;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(idx * 4);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_HEADER:  model_cfg.header_byte = data[7:0];
			REG_POLY:    model_cfg.crc_polynomial = data[7:0];
			REG_MIN_WIN: model_cfg.min_window = data[6:0];
			default:     model_cfg.min_length = data[7:0];
		endcase
		// read back
		@(posedge clk);
		psel <= 1'b1;
		paddr <= PADDR_W'(idx * 4);
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata !== (data & mask)) begin
			$display("%0t: register %0d readback expected %h actual %h",
				$time, idx, data & mask, prdata);
			err_cnt++;
		end
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_cfg(logic [7:0] hdr, logic [7:0] poly, logic [7:0] mw, logic [7:0] ml);
		settle();
		reg_write(REG_HEADER, hdr);
		reg_write(REG_POLY, poly);
		reg_write(REG_MIN_WIN, mw);
		reg_write(REG_MIN_LEN, ml);
	endtask

	task automatic push_frame(int len, bit corrupt);
		logic [7:0] f[$];
		logic [7:0] crc;
		logic [7:0] b;
		int pos;
		f.push_back(model_cfg.header_byte);
		f.push_back(8'($urandom));
		if (len == 0) begin
			f.push_back(8'h00);
		end else begin
			f.push_back(8'(len));
			crc = crc8_next(8'h00, 8'(len), model_cfg.crc_polynomial);
			for (int i = 1; i < len; i++) begin
				b = 8'($urandom);
				f.push_back(b);
				crc = crc8_next(crc, b, model_cfg.crc_polynomial);
			end
			f.push_back(crc);
		end
		if (corrupt) begin
			pos = $urandom_range(0, f.size() - 1);
			f[pos] = f[pos] ^ (8'h01 << $urandom_range(0, 7));
		end
		foreach (f[i])
			put(KIND_PUSH, f[i]);
	endtask

	// act on check verdicts the way a receiver would: pop what is reported, check again
	task automatic resolve();
		for (int rounds = 0; rounds < 8; rounds++) begin
			drain();
			if (last_check.status != ST_FRAME && last_check.status != ST_DISCARD)
				break;
			pop_n(last_check.count);
			put(KIND_CHECK, 8'($urandom));
		end
		drain();
		if (win_fill > 300)
			pop_n(win_fill);
	endtask

	function automatic int pick_len();
		int lo;
		lo = model_cfg.min_length;
		if (lo >= 200 || $urandom_range(0, 49) == 0)
			return $urandom_range(lo, 255);
		return (lo + $urandom_range(0, 6) > 255) ? 255 : lo + $urandom_range(0, 6);
	endfunction

	task automatic random_phase(int n_items);
		int stop_at;
		int r;
		stop_at = issued + n_items;
		while (issued < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 3)) put(KIND_PUSH, 8'($urandom));
				push_frame(pick_len(), $urandom_range(0, 7) == 0);
				put(KIND_CHECK, 8'($urandom));
				resolve();
			end else if (r < 75) begin
				repeat ($urandom_range(1, 10))
					put(KIND_PUSH, ($urandom_range(0, 3) == 0) ?
						model_cfg.header_byte : 8'($urandom));
				put(KIND_CHECK, 8'($urandom));
				resolve();
			end else if (r < 85) begin
				pop_n($urandom_range(1, 5));
			end else if (r < 95) begin
				put(KIND_CHECK, 8'($urandom));
			end else begin
				put(KIND_NOP, 8'($urandom));
			end
		end
	endtask

	initial begin : stim
		logic [7:0] b;
		model_cfg = '{header_byte: 8'hF7, crc_polynomial: 8'h07, min_window: 7'd6,
			min_length: 8'd3};
		win_head = 0;
		win_fill = 0;
		hunting = 1'b0;
		last_check = '{default: '0};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty window, unused kind, one good frame, a bad length
		put(KIND_POP, 8'hFF);
		put(KIND_CHECK, 8'h00);
		put(KIND_NOP, 8'hFF);
		put(KIND_PUSH, 8'hF7);
		put(KIND_PUSH, 8'hFF);
		put(KIND_PUSH, 8'h03);
		put(KIND_PUSH, 8'h00);
		put(KIND_PUSH, 8'hFF);
		put(KIND_PUSH, crc8_next(crc8_next(crc8_next(8'h00, 8'h03, 8'h07), 8'h00, 8'h07),
			8'hFF, 8'h07));
		put(KIND_CHECK, 8'hFF);
		pop_n(6);
		put(KIND_PUSH, 8'hF7);
		put(KIND_PUSH, 8'h12);
		put(KIND_PUSH, 8'h01);
		put(KIND_PUSH, 8'hF7);
		put(KIND_PUSH, 8'h34);
		put(KIND_PUSH, 8'h56);
		put(KIND_CHECK, 8'h00);
		resolve();
		random_phase(150);

		// zero min_window and min_length: short window, zero-length frame
		set_cfg(8'h00, 8'h00, 8'h00, 8'h00);
		pop_n(win_fill);
		put(KIND_CHECK, 8'h00);
		put(KIND_PUSH, 8'h00);
		put(KIND_PUSH, 8'h55);
		put(KIND_CHECK, 8'h00);
		put(KIND_PUSH, 8'h00);
		put(KIND_CHECK, 8'h00);
		resolve();
		random_phase(150);

		set_cfg(8'hFF, 8'hFF, 8'd64, 8'd255);
		random_phase(250);

		set_cfg(8'h5A, 8'h1D, 8'd127, 8'd2);
		random_phase(150);

		// fill the window past full with no header anywhere, then hunt it out
		set_cfg(8'hA5, 8'h31, 8'd1, 8'd1);
		drain();
		pop_n(win_fill);
		repeat (WIN_DEPTH + 3) begin
			b = 8'($urandom);
			if (b == model_cfg.header_byte)
				b = b ^ 8'h01;
			put(KIND_PUSH, b);
		end
		put(KIND_CHECK, 8'h00);
		resolve();
		drain();
		pop_n(win_fill);
		random_phase(100);

		while (issued < ITEM_TARGET) begin
			set_cfg(8'($urandom), 8'($urandom), 8'($urandom_range(0, 20)),
				8'($urandom_range(0, 8)));
			random_phase(250);
		end

		set_cfg(8'hF7, 8'h07, 8'd6, 8'd3);
		calm = 1'b1;
		random_phase(150);

		drain();
		repeat (40) @(posedge clk);
		if (err_cnt == 0 && pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
